[rtl/core/roulette_wheel_selector_core_macros.svh]
// ----------------------------------------------------------------------------
// Roulette wheel selector assertion macros
// Shared concurrent assertion wrappers for the selector checkers.
// ----------------------------------------------------------------------------
`ifndef ROULETTE_WHEEL_SELECTOR_CORE_MACROS_SVH
`define ROULETTE_WHEEL_SELECTOR_CORE_MACROS_SVH

// Clocked property with reset disable.
`define RWS_ASSERT_PROP(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RWS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    `RWS_ASSERT_PROP(lbl, ck, rn, (ante) |=> (cons), msg)

`endif

[rtl/core/rws_pkg.sv]
// ----------------------------------------------------------------------------
// Roulette wheel selector package
// Fixed field widths and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package rws_pkg;

    localparam int SLOT_W = 6;
    localparam int POP_W  = 7;
    localparam logic [POP_W-1:0] POP_RESET = 7'd50;

    // Controller to datapath
    typedef struct packed {
        logic latch;       // input transfer: capture fields, arm multiplier
        logic load_read;   // read old fitness of the load slot
        logic load_write;  // write new fitness, adjust total
        logic mul_step;    // one shift-add step of random * total
        logic walk_start;  // clear the walk pipeline
        logic walk_run;    // advance the walk pipeline
        logic capture;     // hold the walk outcome
        logic push;        // move the outcome into the output register
    } rws_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic load_in_range;
        logic mul_last;
        logic walk_done;
        logic out_free;
    } rws_status_t;

endpackage

[rtl/core/rws_in_if.sv]
// ----------------------------------------------------------------------------
// Selector input channel
// Valid/ready channel carrying one load or pick item.
// ----------------------------------------------------------------------------
interface rws_in_if import rws_pkg::*; #(
    parameter int FITNESS_WIDTH = 24,
    parameter int RANDOM_WIDTH  = 16
) ();

    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [SLOT_W-1:0]        slot;
    logic [FITNESS_WIDTH-1:0] fitness;
    logic [RANDOM_WIDTH-1:0]  random_value;

    modport source (output valid, mode, slot, fitness, random_value, input ready);
    modport sink   (input valid, mode, slot, fitness, random_value, output ready);

endinterface

[rtl/core/rws_out_if.sv]
// ----------------------------------------------------------------------------
// Selector result channel
// Valid/ready channel carrying one pick result.
// ----------------------------------------------------------------------------
interface rws_out_if import rws_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] selected_slot;
    logic              fell_back;

    modport source (output valid, selected_slot, fell_back, input ready);
    modport sink   (input valid, selected_slot, fell_back, output ready);

endinterface

[rtl/core/roulette_wheel_selector_core.sv]
// ----------------------------------------------------------------------------
// Roulette wheel selector core
// Fitness-proportionate selection over a table of loadable fitness values.
// ----------------------------------------------------------------------------
// Channels: in_ch takes load items (mode 0: slot, fitness) and pick items
// (mode 1: random_value); out_ch returns one result per pick, none per load.
// cfg_we/cfg_wdata write population_size; the user must write it only while the
// core is idle, which the core itself does not enforce.
// Load: in_ch.ready is low after the transfer through the read of the old
// entry, then the write and total update on the RAM.
// Pick: the product random_value * total is formed by a serial shift-add,
// then the walk reads one slot per cycle from the RAM.
// One item is in work at a time; in_ch.ready rises as the result is loaded.
// Stall: the result waits in the output register; the next item may already
// be taken, and a new pick holds its result until the register frees.
// Reset: table reads as all zero, total zero, population_size 50, no result.
// ----------------------------------------------------------------------------
module roulette_wheel_selector_core import rws_pkg::*; #(
    parameter int MAX_POPULATION = 64,
    parameter int FITNESS_WIDTH  = 24,
    parameter int RANDOM_WIDTH   = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [POP_W-1:0] cfg_wdata,
    rws_in_if.sink           in_ch,
    rws_out_if.source        out_ch
);

    rws_cmd_t    cmd;
    rws_status_t sts;

    rws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_mode  (in_ch.mode),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rws_datapath #(
        .MAX_POPULATION (MAX_POPULATION),
        .FITNESS_WIDTH  (FITNESS_WIDTH),
        .RANDOM_WIDTH   (RANDOM_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_slot       (in_ch.slot),
        .in_fitness    (in_ch.fitness),
        .in_random     (in_ch.random_value),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .out_slot      (out_ch.selected_slot),
        .out_fell_back (out_ch.fell_back)
    );

endmodule

[rtl/core/rws_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rws_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/rws_ctrl.sv]
// ----------------------------------------------------------------------------
// Selector controller
// Sequences loads, the product setup and the slot walk of a pick.
// ----------------------------------------------------------------------------
module rws_ctrl import rws_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_mode,
    output logic        in_ready,
    input  rws_status_t sts,
    output rws_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_WR,
        ST_MUL,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.latch  = 1'b1;
                    state_next = in_mode ? ST_MUL : ST_LOAD_RD;
                end
            end
            ST_LOAD_RD:
            begin
                cmd.load_read = 1'b1;
                // out-of-range slot: load is dropped
                state_next = sts.load_in_range ? ST_LOAD_WR : ST_IDLE;
            end
            ST_LOAD_WR:
            begin
                cmd.load_write = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (sts.mul_last)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.walk_run = 1'b1;
                if (sts.walk_done)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

[rtl/core/rws_datapath.sv]
// ----------------------------------------------------------------------------
// Selector datapath
// Fitness table, running total, serial product, walk pipeline, result register.
// ----------------------------------------------------------------------------
module rws_datapath import rws_pkg::*; #(
    parameter int MAX_POPULATION = 64,
    parameter int FITNESS_WIDTH  = 24,
    parameter int RANDOM_WIDTH   = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [POP_W-1:0]         cfg_wdata,
    input  logic [SLOT_W-1:0]        in_slot,
    input  logic [FITNESS_WIDTH-1:0] in_fitness,
    input  logic [RANDOM_WIDTH-1:0]  in_random,
    input  rws_cmd_t                 cmd,
    output rws_status_t              sts,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [SLOT_W-1:0]        out_slot,
    output logic                     out_fell_back
);

    localparam int IW = $clog2(MAX_POPULATION);
    localparam int TW = FITNESS_WIDTH + IW;
    localparam int PW = TW + RANDOM_WIDTH;
    localparam int CW = $clog2(RANDOM_WIDTH);

    logic [POP_W-1:0]          pop_reg;
    logic [TW-1:0]             total_reg, total_next;
    logic [MAX_POPULATION-1:0] valid_bits_reg;

    logic [SLOT_W-1:0]         slot_reg;
    logic [FITNESS_WIDTH-1:0]  fit_reg;

    logic [PW-1:0]             mcand_reg;
    logic [RANDOM_WIDTH-1:0]   mplier_reg;
    logic [PW-1:0]             prod_reg, prod_next;
    logic [CW-1:0]             mul_cnt_reg;

    logic [IW-1:0]             rd_idx_reg;
    logic                      issue_on_reg;
    logic                      p1_vld_reg;
    logic                      p1_live_reg;
    logic [IW-1:0]             p1_idx_reg;
    logic                      t_vld_reg;
    logic [IW-1:0]             t_idx_reg;
    logic [PW-1:0]             term_reg, term_next;
    logic [PW-1:0]             sc_reg, sc_next;

    logic [IW-1:0]             res_slot_reg;
    logic                      res_fell_reg;
    logic                      out_valid_reg;
    logic [SLOT_W-1:0]         out_slot_reg;
    logic                      out_fell_reg;

    logic [31:0]               slot_wide;
    logic [31:0]               pop_wide;
    logic [31:0]               n_wide;
    logic [31:0]               res_wide;
    logic                      in_range;
    logic [IW-1:0]             slot_idx;
    logic [IW-1:0]             last_idx;
    logic [FITNESS_WIDTH-1:0]  old_fit;
    logic [FITNESS_WIDTH-1:0]  rd_fit;
    logic                      issue;
    logic                      hit;
    logic                      at_end;

    logic                      ram_re;
    logic [IW-1:0]             ram_raddr;
    logic [FITNESS_WIDTH-1:0]  ram_rdata;

    // Slot range and clamped population
    always_comb
    begin
        slot_wide = 32'(slot_reg);
        in_range  = slot_wide < 32'(MAX_POPULATION);
        slot_idx  = slot_wide[IW-1:0];
        pop_wide  = 32'(pop_reg);
        if (pop_wide == 32'd0)
        begin
            n_wide = 32'd1;
        end
        else if (pop_wide > 32'(MAX_POPULATION))
        begin
            n_wide = 32'(MAX_POPULATION);
        end
        else
        begin
            n_wide = pop_wide;
        end
        last_idx = IW'(n_wide - 32'd1);
        res_wide = 32'(res_slot_reg);
    end

    // Never-written entries read as zero
    assign old_fit    = valid_bits_reg[slot_idx] ? ram_rdata : '0;
    assign total_next = total_reg - TW'(old_fit) + TW'(fit_reg);

    assign prod_next  = prod_reg + (mplier_reg[0] ? mcand_reg : '0);

    assign issue      = cmd.walk_run && issue_on_reg;
    assign rd_fit     = p1_live_reg ? ram_rdata : '0;
    // fitness * (2^RANDOM_WIDTH - 1)
    assign term_next  = (PW'(rd_fit) << RANDOM_WIDTH) - PW'(rd_fit);
    assign sc_next    = sc_reg + term_reg;
    assign hit        = t_vld_reg && (sc_next > prod_reg);
    assign at_end     = t_vld_reg && (t_idx_reg == last_idx);

    assign ram_re     = cmd.load_read || issue;
    assign ram_raddr  = cmd.load_read ? slot_idx : rd_idx_reg;

    always_comb
    begin
        sts               = '0;
        sts.load_in_range = in_range;
        sts.mul_last      = (mul_cnt_reg == CW'(RANDOM_WIDTH - 1));
        sts.walk_done     = hit || at_end;
        sts.out_free      = !out_valid_reg || out_ready;
    end

    rws_ram #(
        .WIDTH (FITNESS_WIDTH),
        .DEPTH (MAX_POPULATION)
    ) u_fitness_ram (
        .clk   (clk),
        .we    (cmd.load_write),
        .waddr (slot_idx),
        .wdata (fit_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_reg        <= POP_RESET;
            total_reg      <= '0;
            valid_bits_reg <= '0;
            mul_cnt_reg    <= '0;
            issue_on_reg   <= 1'b0;
            p1_vld_reg     <= 1'b0;
            t_vld_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pop_reg <= cfg_wdata;
            end
            if (cmd.load_write)
            begin
                total_reg                <= total_next;
                valid_bits_reg[slot_idx] <= 1'b1;
            end
            if (cmd.latch)
            begin
                mul_cnt_reg <= '0;
            end
            else if (cmd.mul_step)
            begin
                mul_cnt_reg <= mul_cnt_reg + CW'(1);
            end
            if (cmd.walk_start)
            begin
                issue_on_reg <= 1'b1;
                p1_vld_reg   <= 1'b0;
                t_vld_reg    <= 1'b0;
            end
            else if (cmd.walk_run)
            begin
                if (issue && (rd_idx_reg == last_idx))
                begin
                    issue_on_reg <= 1'b0;
                end
                p1_vld_reg <= issue;
                t_vld_reg  <= p1_vld_reg;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            slot_reg   <= in_slot;
            fit_reg    <= in_fitness;
            mcand_reg  <= PW'(total_reg);
            mplier_reg <= in_random;
            prod_reg   <= '0;
        end
        else if (cmd.mul_step)
        begin
            prod_reg   <= prod_next;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
        if (cmd.walk_start)
        begin
            rd_idx_reg <= '0;
            sc_reg     <= '0;
        end
        else if (cmd.walk_run)
        begin
            if (issue)
            begin
                rd_idx_reg <= rd_idx_reg + IW'(1);
            end
            p1_idx_reg  <= rd_idx_reg;
            p1_live_reg <= valid_bits_reg[rd_idx_reg];
            term_reg    <= term_next;
            t_idx_reg   <= p1_idx_reg;
            if (t_vld_reg)
            begin
                sc_reg <= sc_next;
            end
        end
        if (cmd.capture)
        begin
            // on a miss t_idx_reg is already the last slot in use
            res_slot_reg <= t_idx_reg;
            res_fell_reg <= !hit;
        end
        if (cmd.push)
        begin
            out_slot_reg <= SLOT_W'(res_wide);
            out_fell_reg <= res_fell_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_slot      = out_slot_reg;
    assign out_fell_back = out_fell_reg;

endmodule

[rtl/core/rws_checker.sv]
// ----------------------------------------------------------------------------
// Selector port checker
// Port-level properties of the selector core, bound to the top level.
// ----------------------------------------------------------------------------
`include "roulette_wheel_selector_core_macros.svh"

module rws_checker import rws_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              in_mode,
    input logic              out_valid,
    input logic              out_ready,
    input logic [SLOT_W-1:0] out_selected_slot,
    input logic              out_fell_back
);

    `RWS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `RWS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_selected_slot) && $stable(out_fell_back), "result changed while stalled")
    `RWS_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready, "input taken while an item is in work")
    `RWS_ASSERT_NEXT(a_load_silent, clk, rst_n, in_valid && in_ready && !in_mode, !$rose(out_valid), "load transfer produced a result")

endmodule

bind roulette_wheel_selector_core rws_checker u_rws_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_mode           (in_ch.mode),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_selected_slot (out_ch.selected_slot),
    .out_fell_back     (out_ch.fell_back)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Roulette wheel selector testbench
// Loads fitness tables and issues picks through the valid/ready channels. A
// local copy of the fitness table and its total predicts each pick not typed
// in its row, and every result is checked in order. The run goes through
// several population sizes, including zero and values past the table size,
// under varied idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import rws_pkg::*;

    localparam int FIT_W     = 24;
    localparam int RND_W     = 16;
    localparam int MAX_POP   = 64;
    localparam int RND_MAX   = (1 << RND_W) - 1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_PICK = 1'b1;

    localparam int N_DIRECTED     = 24;
    localparam int N_PHASES       = 6;
    localparam int RAND_PER_PHASE = 117;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 100;
    localparam int CYCLE_LIMIT    = 1000000;

    typedef struct packed {
        logic             mode;
        logic [SLOT_W-1:0] slot;
        logic [FIT_W-1:0] fitness;
        logic [RND_W-1:0] rnd;
    } sel_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              fell_back;
    } pick_result_t;

    // typed: expectation given in the row rather than by the predictor
    typedef struct packed {
        sel_item_t    item;
        logic         typed;
        pick_result_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [POP_W-1:0] cfg_wdata;

    rws_in_if #(.FITNESS_WIDTH(FIT_W), .RANDOM_WIDTH(RND_W)) in_ch ();
    rws_out_if out_ch ();

    roulette_wheel_selector_core #(
        .MAX_POPULATION(MAX_POP),
        .FITNESS_WIDTH (FIT_W),
        .RANDOM_WIDTH  (RND_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // Predictor state
    logic [FIT_W-1:0] fit_table [MAX_POP];
    longint unsigned  fit_sum;
    logic [POP_W-1:0] pop_size;

    pick_result_t pick_expect_q [$];

    int errors;
    int items_sent;
    int picks_checked;
    int fallbacks_seen;
    int src_idle_pct;
    int sink_stall_pct;
    longint unsigned cycle_count;

    stim_row_t directed_rows [N_DIRECTED];

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int active_slots();
        int n;
        n = pop_size;
        if (n == 0)
            n = 1;
        if (n > MAX_POP)
            n = MAX_POP;
        return n;
    endfunction

    function automatic void apply_load(logic [SLOT_W-1:0] slot, logic [FIT_W-1:0] fit);
        fit_sum = fit_sum - fit_table[slot] + fit;
        fit_table[slot] = fit;
    endfunction

    // First slot whose running sum times RND_MAX beats rnd times the total.
    function automatic pick_result_t predict_pick(logic [RND_W-1:0] rnd);
        longint unsigned target;
        longint unsigned acc;
        int n;
        pick_result_t res;
        n = active_slots();
        target = fit_sum * rnd;
        acc = 0;
        res.slot = SLOT_W'(n - 1);
        res.fell_back = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            acc += fit_table[i];
            if (acc * RND_MAX > target)
            begin
                res.slot = SLOT_W'(i);
                res.fell_back = 1'b0;
                return res;
            end
        end
        return res;
    endfunction

    function automatic sel_item_t random_item();
        sel_item_t it;
        int pick;
        it.mode = ($urandom_range(99) < 60) ? MODE_PICK : MODE_LOAD;
        if ($urandom_range(99) < 75)
            it.slot = SLOT_W'($urandom_range(active_slots() - 1));
        else
            it.slot = SLOT_W'($urandom_range(MAX_POP - 1));
        pick = $urandom_range(9);
        case (pick)
            0:       it.fitness = '0;
            1:       it.fitness = '1;
            2, 3:    it.fitness = FIT_W'($urandom_range(255));
            default: it.fitness = FIT_W'($urandom());
        endcase
        pick = $urandom_range(9);
        case (pick)
            0:       it.rnd = '0;
            1:       it.rnd = '1;
            default: it.rnd = RND_W'($urandom_range(RND_MAX));
        endcase
        return it;
    endfunction

    // Called at a falling edge, returns at the falling edge after the transfer.
    task automatic send_item(input sel_item_t it, input logic typed, input pick_result_t want);
        pick_result_t exp_res;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.mode         = it.mode;
        in_ch.slot         = it.slot;
        in_ch.fitness      = it.fitness;
        in_ch.random_value = it.rnd;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        if (it.mode == MODE_LOAD)
            apply_load(it.slot, it.fitness);
        else
        begin
            exp_res = typed ? want : predict_pick(it.rnd);
            pick_expect_q = {pick_expect_q, exp_res};
        end
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (pick_expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_pop_size(input logic [POP_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we    = 1'b0;
        pop_size  = val;
    endtask

    always @(negedge clk)
        out_ch.ready = rst_n && ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        pick_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pick_expect_q.size() == 0)
            begin
                $error("result with none pending: selected_slot %0d fell_back %0d",
                       out_ch.selected_slot, out_ch.fell_back);
                errors++;
            end
            else
            begin
                want = pick_expect_q.pop_front();
                picks_checked++;
                if (out_ch.fell_back)
                    fallbacks_seen++;
                if (out_ch.selected_slot !== want.slot)
                begin
                    $error("selected_slot: expected %0d, got %0d",
                           want.slot, out_ch.selected_slot);
                    errors++;
                end
                if (out_ch.fell_back !== want.fell_back)
                begin
                    $error("fell_back: expected %0d, got %0d",
                           want.fell_back, out_ch.fell_back);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        pick_result_t none;
        int pop_plan [N_PHASES];
        int src_plan [N_PHASES];
        int sink_plan [N_PHASES];

        none = '0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        in_ch.valid        = 1'b0;
        in_ch.mode         = MODE_LOAD;
        in_ch.slot         = '0;
        in_ch.fitness      = '0;
        in_ch.random_value = '0;
        out_ch.ready       = 1'b0;
        errors = 0;
        items_sent = 0;
        picks_checked = 0;
        fallbacks_seen = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        for (int i = 0; i < MAX_POP; i++)
            fit_table[i] = '0;
        fit_sum  = 0;
        pop_size = POP_RESET;

        // slots past the population still count in the total
        directed_rows = '{
            '{'{MODE_PICK, 6'd0,  24'h000000, 16'h0000}, 1'b1, '{6'd49, 1'b1}},
            '{'{MODE_PICK, 6'd63, 24'hFFFFFF, 16'hFFFF}, 1'b1, '{6'd49, 1'b1}},
            '{'{MODE_LOAD, 6'd0,  24'hFFFFFF, 16'h0000}, 1'b0, none},
            '{'{MODE_PICK, 6'd0,  24'h000000, 16'h0000}, 1'b1, '{6'd0, 1'b0}},
            '{'{MODE_PICK, 6'd0,  24'h000000, 16'hFFFF}, 1'b0, none},
            '{'{MODE_LOAD, 6'd63, 24'hFFFFFF, 16'hFFFF}, 1'b0, none},
            '{'{MODE_PICK, 6'd0,  24'h000000, 16'hFFFF}, 1'b0, none},
            '{'{MODE_PICK, 6'd0,  24'h000000, 16'h7FFF}, 1'b0, none},
            '{'{MODE_PICK, 6'd0,  24'h000000, 16'h8000}, 1'b0, none},
            '{'{MODE_LOAD, 6'd0,  24'h000000, 16'h0000}, 1'b0, none},
            '{'{MODE_PICK, 6'd0,  24'h000000, 16'h0000}, 1'b0, none},
            '{'{MODE_LOAD, 6'd63, 24'h000000, 16'h0000}, 1'b0, none},
            '{'{MODE_LOAD, 6'd49, 24'h000001, 16'h0000}, 1'b0, none},
            '{'{MODE_PICK, 6'd0,  24'h000000, 16'hFFFF}, 1'b0, none},
            '{'{MODE_PICK, 6'd0,  24'h000000, 16'hFFFE}, 1'b0, none},
            '{'{MODE_LOAD, 6'd5,  24'hAAAAAA, 16'h0000}, 1'b0, none},
            '{'{MODE_LOAD, 6'd17, 24'h555555, 16'h0000}, 1'b0, none},
            '{'{MODE_LOAD, 6'd33, 24'h800001, 16'h0000}, 1'b0, none},
            '{'{MODE_PICK, 6'd0,  24'h000000, 16'h5555}, 1'b0, none},
            '{'{MODE_PICK, 6'd0,  24'h000000, 16'hAAAA}, 1'b0, none},
            '{'{MODE_PICK, 6'd0,  24'h000000, 16'h8000}, 1'b0, none},
            '{'{MODE_PICK, 6'd0,  24'h000000, 16'h0001}, 1'b0, none},
            '{'{MODE_LOAD, 6'd5,  24'hAAAAAA, 16'h0000}, 1'b0, none},
            '{'{MODE_PICK, 6'd0,  24'h000000, 16'h0000}, 1'b0, none}
        };

        // population 0 acts as 1, 65 and 127 saturate to the table size
        pop_plan  = '{1, 64, 0, 127, 65, 0};
        src_plan  = '{0, 66, 0, 26, 0, 26};
        sink_plan = '{0, 0, 66, 26, 0, 26};
        pop_plan[N_PHASES-1] = $urandom_range(2, MAX_POP - 1);

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
        drain();

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_pop_size(POP_W'(pop_plan[p]));
            src_idle_pct   = src_plan[p];
            sink_stall_pct = sink_plan[p];
            for (int k = 0; k < RAND_PER_PHASE; k++)
                send_item(random_item(), 1'b0, none);
            drain();
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pick_expect_q.size() != 0)
        begin
            $error("%0d picks never returned a result", pick_expect_q.size());
            errors++;
        end

        $display("sent %0d items over %0d population settings plus reset default",
                 items_sent, N_PHASES);
        $display("checked %0d picks, %0d of them fallbacks, %0d mismatches",
                 picks_checked, fallbacks_seen, errors);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
